// File: rtl/core/qtsg_pkg.sv
// ----------------------------------------------------------------------------
// qtsg_pkg
// Shared constants, types and the LFSR step for the QPSK test sample source.
// ----------------------------------------------------------------------------
package qtsg_pkg;

    localparam int LFSR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int SYM_W    = 2;
    localparam int NOISE_W  = 9;

    typedef logic [LFSR_W-1:0]          lfsr_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SYM_W-1:0]           symbol_t;

    localparam lfsr_t   SEED_DEFAULT  = 16'hACE1;
    localparam lfsr_t   FEEDBACK_MASK = 16'hB400;
    localparam sample_t AMPLITUDE     = 16'sd16384;
    localparam sample_t NOISE_OFFSET  = 16'sd256;

    localparam symbol_t SYM_PP = 2'd0;
    localparam symbol_t SYM_MP = 2'd1;
    localparam symbol_t SYM_MM = 2'd2;
    localparam symbol_t SYM_PM = 2'd3;

    // One Galois step: shift right, fold the mask in when the lsb falls out
    function automatic lfsr_t lfsr_next(input lfsr_t s);
        lfsr_t n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ FEEDBACK_MASK;
        end
        return n;
    endfunction

    // Result item
    typedef struct packed {
        sample_t i_sample;
        sample_t q_sample;
        symbol_t symbol;
    } sample_item_t;

endpackage

// File: rtl/core/qtsg_sample_map.sv
// ----------------------------------------------------------------------------
// qtsg_sample_map
// Three unrolled LFSR steps and the symbol/noise mapping for one sample.
// ----------------------------------------------------------------------------
module qtsg_sample_map (
    input  qtsg_pkg::lfsr_t        state_in,
    output qtsg_pkg::lfsr_t        state_out,
    output qtsg_pkg::sample_item_t item
);
    import qtsg_pkg::*;

    lfsr_t   s1;
    lfsr_t   s2;
    lfsr_t   s3;
    symbol_t sym;
    sample_t i_base;
    sample_t q_base;
    sample_t i_noise;
    sample_t q_noise;

    always_comb begin
        s1 = lfsr_next(state_in);
        s2 = lfsr_next(s1);
        s3 = lfsr_next(s2);
        state_out = s3;

        sym = s1[SYM_W-1:0];
        case (sym)
            SYM_PP: begin
                i_base = AMPLITUDE;
                q_base = AMPLITUDE;
            end
            SYM_MP: begin
                i_base = -AMPLITUDE;
                q_base = AMPLITUDE;
            end
            SYM_MM: begin
                i_base = -AMPLITUDE;
                q_base = -AMPLITUDE;
            end
            default: begin
                i_base = AMPLITUDE;
                q_base = -AMPLITUDE;
            end
        endcase

        // noise = low nine bits minus 256, always in -256..255
        i_noise = sample_t'({{(SAMPLE_W-NOISE_W){1'b0}}, s2[NOISE_W-1:0]}) - NOISE_OFFSET;
        q_noise = sample_t'({{(SAMPLE_W-NOISE_W){1'b0}}, s3[NOISE_W-1:0]}) - NOISE_OFFSET;

        item.i_sample = i_base + i_noise;
        item.q_sample = q_base + q_noise;
        item.symbol   = sym;
    end

endmodule

// File: rtl/core/qpsk_test_sample_generator.sv
// ----------------------------------------------------------------------------
// qpsk_test_sample_generator
// Noisy QPSK IQ source driven by a 16-bit Galois LFSR.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_advance
//  m_       out        m_valid/m_ready    m_i_sample, m_q_sample, m_symbol
//  cfg_     in         cfg_we             cfg_wdata (LFSR seed)
//
// One item per cycle sustained while m_ready keeps the output free.
// The three LFSR steps and the mapping sit between the input register and
// the output register. Items with advance low are consumed with no result.
// Reset loads the LFSR with 0xACE1; a seed write loads it at once.
// A stalled output holds its item while the input register keeps one more.
// ----------------------------------------------------------------------------
module qpsk_test_sample_generator (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  qtsg_pkg::lfsr_t       cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_advance,

    output logic                  m_valid,
    input  logic                  m_ready,
    output qtsg_pkg::sample_t     m_i_sample,
    output qtsg_pkg::sample_t     m_q_sample,
    output qtsg_pkg::symbol_t     m_symbol
);
    import qtsg_pkg::*;

    logic         in_valid_reg;
    logic         in_adv_reg;
    lfsr_t        state_reg;
    lfsr_t        state_next;
    logic         out_valid_reg;
    sample_item_t out_item_reg;
    sample_item_t item_next;

    logic out_free;
    logic stage_move;

    assign out_free   = !out_valid_reg || m_ready;
    assign stage_move = in_valid_reg && (!in_adv_reg || out_free);
    assign s_ready    = !in_valid_reg || stage_move;

    qtsg_sample_map u_map (
        .state_in  (state_reg),
        .state_out (state_next),
        .item      (item_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_adv_reg <= s_advance;
        end
    end

    // LFSR state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_DEFAULT;
        end else if (cfg_we) begin
            state_reg <= cfg_wdata;
        end else if (stage_move && in_adv_reg) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= stage_move && in_adv_reg;
        end
        if (stage_move && in_adv_reg) begin
            out_item_reg <= item_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_i_sample = out_item_reg.i_sample;
    assign m_q_sample = out_item_reg.q_sample;
    assign m_symbol   = out_item_reg.symbol;

endmodule
